### src/sdspi_pkg.sv
`timescale 1ns / 1ps

package sdspi_pkg;

    // Input beat opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds
    localparam logic RK_EXCHANGE = 1'b0;
    localparam logic RK_DONE     = 1'b1;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CARD    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_KIND    = 2'd3;

    // Response kinds
    localparam logic [2:0] KIND_R1  = 3'd0;
    localparam logic [2:0] KIND_R1B = 3'd1;
    localparam logic [2:0] KIND_R2  = 3'd2;
    localparam logic [2:0] KIND_MAX = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_READY_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_BUSY_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT    = 2'd2;

    localparam logic [15:0] READY_TIMEOUT_RESET = 16'd20;
    localparam logic [15:0] BUSY_TIMEOUT_RESET  = 16'd100;
    localparam logic [3:0]  POLL_LIMIT_RESET    = 4'd8;

    localparam logic [7:0] IDLE_BYTE      = 8'hff;
    localparam logic [7:0] START_BITS     = 8'h40;
    localparam logic [7:0] BIT7_MASK      = 8'h80;
    localparam logic [7:0] ILLEGAL_CMD    = 8'h04;
    localparam logic [5:0] CMD_STOP_TRANS = 6'd12;

    localparam int PADDR_W = 4;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_READY   = 7'b0000010,
        PH_SEND    = 7'b0000100,
        PH_DISCARD = 7'b0001000,
        PH_POLL    = 7'b0010000,
        PH_COLLECT = 7'b0100000,
        PH_BUSY    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [7:0]  crc_byte;
        logic [2:0]  response_kind;
        logic [7:0]  received_byte;
    } in_beat_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  transmit_byte;
        logic [1:0]  status;
        logic [7:0]  first_response_byte;
        logic [31:0] extra_response;
    } out_beat_t;

endpackage

### src/sd_spi_command_transaction_top.sv
`timescale 1ns / 1ps

// Results are registered: an accepted input beat's result beat shows on m_ in the next cycle.
// Throughput: one input beat per cycle; s_ready drops only while a result
//   waits in the output register and m_ready is low.
// Reset: aresetn low at a rising edge returns the sequencer to idle, drops
//   any pending result and restores the timeout and poll-limit registers.
module sd_spi_command_transaction_top
    import sdspi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    // result beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] ready_timeout_reg;
    logic [15:0] busy_timeout_reg;
    logic [3:0]  poll_limit_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_timeout_reg <= READY_TIMEOUT_RESET;
            busy_timeout_reg  <= BUSY_TIMEOUT_RESET;
            poll_limit_reg    <= POLL_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_READY_TIMEOUT: ready_timeout_reg <= pwdata[15:0];
                REG_BUSY_TIMEOUT:  busy_timeout_reg  <= pwdata[15:0];
                REG_POLL_LIMIT:    poll_limit_reg    <= pwdata[3:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_READY_TIMEOUT: prdata = {16'd0, ready_timeout_reg};
            REG_BUSY_TIMEOUT:  prdata = {16'd0, busy_timeout_reg};
            REG_POLL_LIMIT:    prdata = {28'd0, poll_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Transaction state
    // ------------------------------------------------------------------
    phase_t      phase_reg,   phase_next;
    logic [2:0]  send_index_reg, send_index_next;
    logic [3:0]  poll_count_reg, poll_count_next;
    logic [15:0] tick_timer_reg, tick_timer_next;
    logic [5:0]  cmd_reg,     cmd_next;
    logic [31:0] arg_reg,     arg_next;
    logic [7:0]  crc_reg,     crc_next;
    logic [2:0]  kind_reg,    kind_next;
    logic [7:0]  head_reg,    head_next;
    logic [31:0] tail_reg,    tail_next;
    logic [2:0]  remain_reg,  remain_next;

    logic        m_valid_reg;
    out_beat_t   m_data_reg;

    logic        s_fire;
    logic        res_valid;
    out_beat_t   res;

    // The output register takes a new beat when empty or draining this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // One of the six command frame bytes; start and stop bits forced.
    function automatic logic [7:0] command_byte(input logic [2:0] k,
                                                input logic [5:0] cmd,
                                                input logic [31:0] arg,
                                                input logic [7:0] crc);
        logic [7:0] b;
        case (k)
            3'd0:    b = {2'b00, cmd} | START_BITS;
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = crc | 8'h01;
        endcase
        return b;
    endfunction

    // Response bytes beyond the R1 byte: R1 and R1B none, R2 one, R3/R7 four.
    function automatic logic [2:0] reply_extra(input logic [2:0] kind);
        logic [2:0] n;
        if (kind <= KIND_R1B)     n = 3'd0;
        else if (kind == KIND_R2) n = 3'd1;
        else                      n = 3'd4;
        return n;
    endfunction

    logic [7:0]  rx;
    logic [15:0] tick_inc;
    logic [3:0]  poll_inc;
    logic [2:0]  extra_n;
    logic [1:0]  tail_pos;
    logic [2:0]  remain_dec;

    assign rx         = s_data.received_byte;
    assign tick_inc   = tick_timer_reg + 16'd1;
    assign poll_inc   = poll_count_reg + 4'd1;
    assign extra_n    = reply_extra(kind_reg);
    assign tail_pos   = 2'(extra_n - remain_reg);
    assign remain_dec = remain_reg - 3'd1;

    always_comb begin
        logic [31:0] tail_or;

        phase_next      = phase_reg;
        send_index_next = send_index_reg;
        poll_count_next = poll_count_reg;
        tick_timer_next = tick_timer_reg;
        cmd_next        = cmd_reg;
        arg_next        = arg_reg;
        crc_next        = crc_reg;
        kind_next       = kind_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        remain_next     = remain_reg;

        // Default result: an idle-byte exchange request.
        res_valid               = 1'b0;
        res.result_kind         = RK_EXCHANGE;
        res.transmit_byte       = IDLE_BYTE;
        res.status              = ST_OK;
        res.first_response_byte = 8'd0;
        res.extra_response      = 32'd0;

        tail_or = tail_reg | ({24'd0, rx} << (5'd24 - {tail_pos, 3'b000}));

        case (s_data.opcode)
            OP_START: begin
                // Latch the command and restart, abandoning any running one.
                cmd_next        = s_data.command_index;
                arg_next        = s_data.argument;
                crc_next        = s_data.crc_byte;
                kind_next       = s_data.response_kind;
                head_next       = 8'd0;
                tail_next       = 32'd0;
                send_index_next = 3'd0;
                poll_count_next = 4'd0;
                tick_timer_next = 16'd0;
                remain_next     = 3'd0;
                res_valid       = 1'b1;
                if (s_data.response_kind > KIND_MAX) begin
                    phase_next      = PH_IDLE;
                    res.result_kind = RK_DONE;
                    res.status      = ST_KIND;
                end else begin
                    phase_next = PH_READY;
                end
            end
            OP_TICK: begin
                // Advance the timer only in the ready and busy waits.
                if (phase_reg == PH_READY || phase_reg == PH_BUSY) begin
                    tick_timer_next = tick_inc;
                    if ((phase_reg == PH_READY && tick_inc >= ready_timeout_reg) ||
                        (phase_reg == PH_BUSY  && tick_inc >= busy_timeout_reg)) begin
                        phase_next              = PH_IDLE;
                        res_valid               = 1'b1;
                        res.result_kind         = RK_DONE;
                        res.status              = ST_TIMEOUT;
                        res.first_response_byte = head_reg;
                        res.extra_response      = tail_reg;
                    end
                end
            end
            OP_BYTE: begin
                unique case (phase_reg)
                    PH_IDLE: ;  // drop stray bytes
                    PH_READY: begin
                        res_valid = 1'b1;
                        if (rx == IDLE_BYTE) begin
                            phase_next        = PH_SEND;
                            send_index_next   = 3'd1;
                            res.transmit_byte = command_byte(3'd0, cmd_reg, arg_reg,
                                                             crc_reg);
                        end
                    end
                    PH_SEND: begin
                        res_valid = 1'b1;
                        if (send_index_reg < 3'd6) begin
                            res.transmit_byte = command_byte(send_index_reg, cmd_reg,
                                                             arg_reg, crc_reg);
                            send_index_next   = send_index_reg + 3'd1;
                        end else begin
                            poll_count_next = 4'd0;
                            phase_next = (cmd_reg == CMD_STOP_TRANS) ? PH_DISCARD
                                                                     : PH_POLL;
                        end
                    end
                    PH_DISCARD: begin
                        res_valid       = 1'b1;
                        phase_next      = PH_POLL;
                        poll_count_next = 4'd0;
                    end
                    PH_POLL: begin
                        res_valid       = 1'b1;
                        poll_count_next = poll_inc;
                        if ((rx & BIT7_MASK) == 8'd0) begin
                            head_next = rx;
                            if ((rx & ILLEGAL_CMD) == 8'd0 && extra_n != 3'd0) begin
                                remain_next = extra_n;
                                phase_next  = PH_COLLECT;
                            end else if (kind_reg == KIND_R1B) begin
                                phase_next      = PH_BUSY;
                                tick_timer_next = 16'd0;
                            end else begin
                                phase_next              = PH_IDLE;
                                res.result_kind         = RK_DONE;
                                res.status = (rx != 8'd0) ? ST_CARD : ST_OK;
                                res.first_response_byte = rx;
                                res.extra_response      = tail_reg;
                            end
                        end else if (poll_inc >= poll_limit_reg) begin
                            phase_next              = PH_IDLE;
                            res.result_kind         = RK_DONE;
                            res.status              = ST_TIMEOUT;
                            res.first_response_byte = head_reg;
                            res.extra_response      = tail_reg;
                        end
                    end
                    PH_COLLECT: begin
                        res_valid   = 1'b1;
                        tail_next   = tail_or;
                        remain_next = remain_dec;
                        if (remain_dec == 3'd0) begin
                            if (kind_reg == KIND_R1B) begin
                                phase_next      = PH_BUSY;
                                tick_timer_next = 16'd0;
                            end else begin
                                phase_next              = PH_IDLE;
                                res.result_kind         = RK_DONE;
                                res.status = (head_reg != 8'd0) ? ST_CARD : ST_OK;
                                res.first_response_byte = head_reg;
                                res.extra_response      = tail_or;
                            end
                        end
                    end
                    PH_BUSY: begin
                        res_valid = 1'b1;
                        if (rx != 8'd0) begin
                            phase_next              = PH_IDLE;
                            res.result_kind         = RK_DONE;
                            res.status = (head_reg != 8'd0) ? ST_CARD : ST_OK;
                            res.first_response_byte = head_reg;
                            res.extra_response      = tail_reg;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;  // unknown opcode: drop
        endcase
    end

    // Control state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            send_index_reg <= 3'd0;
            poll_count_reg <= 4'd0;
            tick_timer_reg <= 16'd0;
            remain_reg     <= 3'd0;
            head_reg       <= 8'd0;
            tail_reg       <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg      <= phase_next;
                send_index_reg <= send_index_next;
                poll_count_reg <= poll_count_next;
                tick_timer_reg <= tick_timer_next;
                remain_reg     <= remain_next;
                head_reg       <= head_next;
                tail_reg       <= tail_next;
            end
            // Load a fresh result or drop the delivered one.
            if (s_fire) begin
                m_valid_reg <= res_valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Latched command fields and result payload hold without reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= cmd_next;
            arg_reg  <= arg_next;
            crc_reg  <= crc_next;
            kind_reg <= kind_next;
            if (res_valid) begin
                m_data_reg <= res;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && res_valid && res.result_kind == RK_DONE) |=> phase_reg == PH_IDLE)
        else $error("finished result did not return sequencer to idle");

    a_send_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SEND) |-> (send_index_reg >= 3'd1 && send_index_reg <= 3'd6))
        else $error("send index out of frame range");

    a_collect_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COLLECT) |-> (remain_reg != 3'd0 && remain_reg <= 3'd4))
        else $error("collect phase with no bytes remaining");

    a_exchange_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RK_EXCHANGE) |->
            (m_data.status == ST_OK && m_data.first_response_byte == 8'd0))
        else $error("exchange request carries completion fields");

endmodule
